>>> hdl/sm83d_pkg.sv
// Shared codes, operand descriptors and helper functions for the SM83 opcode decoder.
package sm83d_pkg;

    localparam logic [7:0] PREFIX_BYTE   = 8'hCB;
    localparam logic [7:0] HALT_BYTE     = 8'h76;
    localparam logic [7:0] JP_IMM_BYTE   = 8'hC3;
    localparam logic [7:0] DI_BYTE       = 8'hF3;
    localparam logic [7:0] EI_BYTE       = 8'hFB;
    localparam logic [7:0] CALL_IMM_BYTE = 8'hCD;

    // Operation numbers.
    localparam logic [5:0] OP_ADD8    = 6'd0;
    localparam logic [5:0] OP_RLCA    = 6'd8;
    localparam logic [5:0] OP_LD16    = 6'd16;
    localparam logic [5:0] OP_ADD16   = 6'd17;
    localparam logic [5:0] OP_LD8     = 6'd18;
    localparam logic [5:0] OP_INC16   = 6'd19;
    localparam logic [5:0] OP_DEC16   = 6'd20;
    localparam logic [5:0] OP_INC8    = 6'd21;
    localparam logic [5:0] OP_DEC8    = 6'd22;
    localparam logic [5:0] OP_NOP     = 6'd23;
    localparam logic [5:0] OP_STOP    = 6'd24;
    localparam logic [5:0] OP_JR      = 6'd25;
    localparam logic [5:0] OP_HALT    = 6'd26;
    localparam logic [5:0] OP_JP      = 6'd27;
    localparam logic [5:0] OP_DI      = 6'd28;
    localparam logic [5:0] OP_EI      = 6'd29;
    localparam logic [5:0] OP_INVALID = 6'd30;
    localparam logic [5:0] OP_CALL    = 6'd31;
    localparam logic [5:0] OP_PUSH    = 6'd32;
    localparam logic [5:0] OP_RST     = 6'd33;
    localparam logic [5:0] OP_RET     = 6'd34;
    localparam logic [5:0] OP_POP     = 6'd35;
    localparam logic [5:0] OP_RETI    = 6'd36;
    localparam logic [5:0] OP_RLC     = 6'd37;
    localparam logic [5:0] OP_BIT     = 6'd45;
    localparam logic [5:0] OP_RES     = 6'd46;
    localparam logic [5:0] OP_SET     = 6'd47;

    // Operand numbers.
    localparam logic [5:0] OD_NONE   = 6'd0;
    localparam logic [5:0] OD_B      = 6'd1;
    localparam logic [5:0] OD_A      = 6'd8;
    localparam logic [5:0] OD_BC     = 6'd9;
    localparam logic [5:0] OD_HL     = 6'd11;
    localparam logic [5:0] OD_NZ     = 6'd13;
    localparam logic [5:0] OD_SP     = 6'd17;
    localparam logic [5:0] OD_MBC    = 6'd18;
    localparam logic [5:0] OD_IMM16  = 6'd22;
    localparam logic [5:0] OD_IMM8   = 6'd23;
    localparam logic [5:0] OD_MIMM16 = 6'd24;
    localparam logic [5:0] OD_SIMM8  = 6'd25;
    localparam logic [5:0] OD_RST0   = 6'd26;
    localparam logic [5:0] OD_MHIGH8 = 6'd34;
    localparam logic [5:0] OD_SPREL  = 6'd35;
    localparam logic [5:0] OD_MHIGHC = 6'd36;
    localparam logic [5:0] OD_BIT0   = 6'd37;

    typedef enum logic [3:0] {
        OK_NONE,
        OK_FIXED,
        OK_REG8,
        OK_R16SP,
        OK_R16AF,
        OK_COND,
        OK_MEMPAIR,
        OK_RSTV,
        OK_BITN
    } operand_kind_t;

    // An operand before it is turned into its final number.
    typedef struct packed {
        operand_kind_t kind;
        logic [2:0]    idx;
        logic [5:0]    code;
    } operand_t;

    // What the first stage learns about a request.
    typedef struct packed {
        logic       prefixed;
        logic [7:0] opcode;
        logic       is_halt;
        logic       is_jp_imm;
        logic       is_di;
        logic       is_ei;
        logic       is_call_imm;
    } class_t;

    function automatic operand_t opd_fixed(input logic [5:0] code);
        operand_t r;
        r.kind = OK_FIXED;
        r.idx  = 3'd0;
        r.code = code;
        return r;
    endfunction

    function automatic operand_t opd_sel(input operand_kind_t kind, input logic [2:0] idx);
        operand_t r;
        r.kind = kind;
        r.idx  = idx;
        r.code = OD_NONE;
        return r;
    endfunction

endpackage

>>> hdl/sm83d_classify.sv
// First stage: picks the byte to decode and flags the opcodes that are matched whole.
module sm83d_classify
    import sm83d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       cls_valid,
    output class_t     cls
);

    logic   valid_reg;
    class_t cls_reg;
    class_t cls_next;

    always_comb
    begin
        cls_next.prefixed    = (first_byte == PREFIX_BYTE);
        cls_next.opcode      = cls_next.prefixed ? second_byte : first_byte;
        cls_next.is_halt     = (first_byte == HALT_BYTE);
        cls_next.is_jp_imm   = (first_byte == JP_IMM_BYTE);
        cls_next.is_di       = (first_byte == DI_BYTE);
        cls_next.is_ei       = (first_byte == EI_BYTE);
        cls_next.is_call_imm = (first_byte == CALL_IMM_BYTE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

>>> hdl/sm83d_decode.sv
// Second stage: works out the operation and the kind of each operand.
module sm83d_decode
    import sm83d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cls_valid,
    input  class_t   cls,
    output logic     dec_valid,
    output logic [5:0] dec_op,
    output operand_t dec_first,
    output operand_t dec_second
);

    logic       valid_reg;
    logic [5:0] op_reg;
    logic [5:0] op_next;
    operand_t   first_reg;
    operand_t   first_next;
    operand_t   second_reg;
    operand_t   second_next;

    logic [1:0] quad;
    logic [2:0] mid;
    logic [2:0] low;
    logic [2:0] pair;
    logic [2:0] sub;

    assign quad = cls.opcode[7:6];
    assign mid  = cls.opcode[5:3];
    assign low  = cls.opcode[2:0];
    assign pair = {1'b0, cls.opcode[5:4]};
    assign sub  = {1'b0, cls.opcode[4:3]};

    always_comb
    begin
        op_next     = OP_INVALID;
        first_next  = opd_fixed(OD_NONE);
        second_next = opd_fixed(OD_NONE);
        if (cls.prefixed)
        begin
            case (quad)
                2'd0:
                begin
                    op_next    = OP_RLC + {3'b000, mid};
                    first_next = opd_sel(OK_REG8, low);
                end
                2'd1: op_next = OP_BIT;
                2'd2: op_next = OP_RES;
                default: op_next = OP_SET;
            endcase
            if (quad != 2'd0)
            begin
                first_next  = opd_sel(OK_BITN, mid);
                second_next = opd_sel(OK_REG8, low);
            end
        end
        else
        begin
            case (quad)
                2'd0:
                begin
                    case (low)
                        3'd0:
                        begin
                            if (mid[2])
                            begin
                                op_next     = OP_JR;
                                first_next  = opd_sel(OK_COND, sub);
                                second_next = opd_fixed(OD_SIMM8);
                            end
                            else
                            begin
                                case (mid[1:0])
                                    2'd0: op_next = OP_NOP;
                                    2'd1:
                                    begin
                                        op_next     = OP_LD16;
                                        first_next  = opd_fixed(OD_MIMM16);
                                        second_next = opd_fixed(OD_SP);
                                    end
                                    2'd2:
                                    begin
                                        op_next    = OP_STOP;
                                        first_next = opd_fixed(OD_IMM8);
                                    end
                                    default:
                                    begin
                                        op_next    = OP_JR;
                                        first_next = opd_fixed(OD_SIMM8);
                                    end
                                endcase
                            end
                        end
                        3'd1:
                        begin
                            if (cls.opcode[3])
                            begin
                                op_next     = OP_ADD16;
                                first_next  = opd_fixed(OD_HL);
                                second_next = opd_sel(OK_R16SP, pair);
                            end
                            else
                            begin
                                op_next     = OP_LD16;
                                first_next  = opd_sel(OK_R16SP, pair);
                                second_next = opd_fixed(OD_IMM16);
                            end
                        end
                        3'd2:
                        begin
                            op_next = OP_LD8;
                            if (cls.opcode[3])
                            begin
                                first_next  = opd_fixed(OD_A);
                                second_next = opd_sel(OK_MEMPAIR, pair);
                            end
                            else
                            begin
                                first_next  = opd_sel(OK_MEMPAIR, pair);
                                second_next = opd_fixed(OD_A);
                            end
                        end
                        3'd3:
                        begin
                            op_next    = cls.opcode[3] ? OP_DEC16 : OP_INC16;
                            first_next = opd_sel(OK_R16SP, pair);
                        end
                        3'd4:
                        begin
                            op_next    = OP_INC8;
                            first_next = opd_sel(OK_REG8, mid);
                        end
                        3'd5:
                        begin
                            op_next    = OP_DEC8;
                            first_next = opd_sel(OK_REG8, mid);
                        end
                        3'd6:
                        begin
                            op_next     = OP_LD8;
                            first_next  = opd_sel(OK_REG8, mid);
                            second_next = opd_fixed(OD_IMM8);
                        end
                        default: op_next = OP_RLCA + {3'b000, mid};
                    endcase
                end
                2'd1:
                begin
                    if (cls.is_halt)
                    begin
                        op_next = OP_HALT;
                    end
                    else
                    begin
                        op_next     = OP_LD8;
                        first_next  = opd_sel(OK_REG8, mid);
                        second_next = opd_sel(OK_REG8, low);
                    end
                end
                2'd2:
                begin
                    op_next     = OP_ADD8 + {3'b000, mid};
                    first_next  = opd_fixed(OD_A);
                    second_next = opd_sel(OK_REG8, low);
                end
                default:
                begin
                    case (low)
                        3'd0:
                        begin
                            if (!mid[2])
                            begin
                                op_next    = OP_RET;
                                first_next = opd_sel(OK_COND, sub);
                            end
                            else
                            begin
                                case (mid[1:0])
                                    2'd0:
                                    begin
                                        op_next     = OP_LD8;
                                        first_next  = opd_fixed(OD_MHIGH8);
                                        second_next = opd_fixed(OD_A);
                                    end
                                    2'd1:
                                    begin
                                        op_next     = OP_ADD16;
                                        first_next  = opd_fixed(OD_SP);
                                        second_next = opd_fixed(OD_SIMM8);
                                    end
                                    2'd2:
                                    begin
                                        op_next     = OP_LD8;
                                        first_next  = opd_fixed(OD_A);
                                        second_next = opd_fixed(OD_MHIGH8);
                                    end
                                    default:
                                    begin
                                        op_next     = OP_LD16;
                                        first_next  = opd_fixed(OD_HL);
                                        second_next = opd_fixed(OD_SPREL);
                                    end
                                endcase
                            end
                        end
                        3'd1:
                        begin
                            if (!cls.opcode[3])
                            begin
                                op_next    = OP_POP;
                                first_next = opd_sel(OK_R16AF, pair);
                            end
                            else
                            begin
                                case (pair[1:0])
                                    2'd0: op_next = OP_RET;
                                    2'd1: op_next = OP_RETI;
                                    2'd2:
                                    begin
                                        op_next    = OP_JP;
                                        first_next = opd_fixed(OD_HL);
                                    end
                                    default:
                                    begin
                                        op_next     = OP_LD16;
                                        first_next  = opd_fixed(OD_SP);
                                        second_next = opd_fixed(OD_HL);
                                    end
                                endcase
                            end
                        end
                        3'd2:
                        begin
                            if (!mid[2])
                            begin
                                op_next     = OP_JP;
                                first_next  = opd_sel(OK_COND, sub);
                                second_next = opd_fixed(OD_IMM16);
                            end
                            else
                            begin
                                op_next = OP_LD8;
                                case (mid[1:0])
                                    2'd0:
                                    begin
                                        first_next  = opd_fixed(OD_MHIGHC);
                                        second_next = opd_fixed(OD_A);
                                    end
                                    2'd1:
                                    begin
                                        first_next  = opd_fixed(OD_MIMM16);
                                        second_next = opd_fixed(OD_A);
                                    end
                                    2'd2:
                                    begin
                                        first_next  = opd_fixed(OD_A);
                                        second_next = opd_fixed(OD_MHIGHC);
                                    end
                                    default:
                                    begin
                                        first_next  = opd_fixed(OD_A);
                                        second_next = opd_fixed(OD_MIMM16);
                                    end
                                endcase
                            end
                        end
                        3'd3:
                        begin
                            if (cls.is_jp_imm)
                            begin
                                op_next    = OP_JP;
                                first_next = opd_fixed(OD_IMM16);
                            end
                            else if (cls.is_di)
                            begin
                                op_next = OP_DI;
                            end
                            else if (cls.is_ei)
                            begin
                                op_next = OP_EI;
                            end
                        end
                        3'd4:
                        begin
                            if (!mid[2])
                            begin
                                op_next     = OP_CALL;
                                first_next  = opd_sel(OK_COND, sub);
                                second_next = opd_fixed(OD_IMM16);
                            end
                        end
                        3'd5:
                        begin
                            if (!cls.opcode[3])
                            begin
                                op_next    = OP_PUSH;
                                first_next = opd_sel(OK_R16AF, pair);
                            end
                            else if (cls.is_call_imm)
                            begin
                                op_next    = OP_CALL;
                                first_next = opd_fixed(OD_IMM16);
                            end
                        end
                        3'd6:
                        begin
                            op_next     = OP_ADD8 + {3'b000, mid};
                            first_next  = opd_fixed(OD_A);
                            second_next = opd_fixed(OD_IMM8);
                        end
                        default:
                        begin
                            op_next    = OP_RST;
                            first_next = opd_sel(OK_RSTV, mid);
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign dec_valid  = valid_reg;
    assign dec_op     = op_reg;
    assign dec_first  = first_reg;
    assign dec_second = second_reg;

endmodule

>>> hdl/sm83d_emit.sv
// Third stage: turns operand kinds into operand numbers and holds the result.
module sm83d_emit
    import sm83d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       dec_valid,
    input  logic [5:0] dec_op,
    input  operand_t   dec_first,
    input  operand_t   dec_second,
    output logic       done,
    output logic [5:0] operation_code,
    output logic [5:0] first_operand,
    output logic [5:0] second_operand
);

    logic       valid_reg;
    logic [5:0] op_reg;
    logic [5:0] first_reg;
    logic [5:0] first_next;
    logic [5:0] second_reg;
    logic [5:0] second_next;

    function automatic logic [5:0] resolve(input operand_t o);
        logic [5:0] r;
        case (o.kind)
            OK_FIXED:   r = o.code;
            OK_REG8:    r = OD_B + {3'b000, o.idx};
            OK_R16SP:   r = (o.idx[1:0] == 2'd3) ? OD_SP : OD_BC + {4'b0000, o.idx[1:0]};
            OK_R16AF:   r = OD_BC + {4'b0000, o.idx[1:0]};
            OK_COND:    r = OD_NZ + {4'b0000, o.idx[1:0]};
            OK_MEMPAIR: r = OD_MBC + {4'b0000, o.idx[1:0]};
            OK_RSTV:    r = OD_RST0 + {3'b000, o.idx};
            OK_BITN:    r = OD_BIT0 + {3'b000, o.idx};
            default:    r = OD_NONE;
        endcase
        return r;
    endfunction

    assign first_next  = resolve(dec_first);
    assign second_next = resolve(dec_second);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= dec_op;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign done           = valid_reg;
    assign operation_code = op_reg;
    assign first_operand  = first_reg;
    assign second_operand = second_reg;

endmodule

>>> hdl/sm83_opcode_decoder_top.sv
// Top level of the SM83 opcode decoder: three pipeline stages in a row.
//
// A request is accepted at a rising edge where start is high and busy is low.
// It carries first_byte and second_byte; second_byte matters only when the
// first byte is the 0xCB prefix. busy is always low, so a new request can be
// given in every cycle.
// The result for a request passes the classify, decode and operand stage
// registers in turn; done is high for exactly one cycle while operation_code,
// first_operand and second_operand hold the decode, and that is the only
// cycle they are valid. Throughput is one request per cycle.
// Results come out in request order. The receiver cannot stall the block, so
// it must take each result in the cycle that done marks it.
// Reset clears the valid bits of all stages, so requests still in flight are
// dropped and done stays low until new requests have passed through.
module sm83_opcode_decoder_top
    import sm83d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       done,
    output logic [5:0] operation_code,
    output logic [5:0] first_operand,
    output logic [5:0] second_operand
);

    logic       cls_valid;
    class_t     cls;
    logic       dec_valid;
    logic [5:0] dec_op;
    operand_t   dec_first;
    operand_t   dec_second;

    assign busy = 1'b0;

    sm83d_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .cls_valid   (cls_valid),
        .cls         (cls)
    );

    sm83d_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls_valid  (cls_valid),
        .cls        (cls),
        .dec_valid  (dec_valid),
        .dec_op     (dec_op),
        .dec_first  (dec_first),
        .dec_second (dec_second)
    );

    sm83d_emit u_emit
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .dec_valid      (dec_valid),
        .dec_op         (dec_op),
        .dec_first      (dec_first),
        .dec_second     (dec_second),
        .done           (done),
        .operation_code (operation_code),
        .first_operand  (first_operand),
        .second_operand (second_operand)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the SM83 opcode decoder: queued requests, own decode, field checks.
module testbench;
    import sm83d_pkg::*;

    typedef struct packed {
        logic [5:0] op;
        logic [5:0] dst;
        logic [5:0] src;
    } decode_t;

    typedef struct packed {
        logic       drain;
        logic [7:0] first;
        logic [7:0] second;
    } fetch_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        decode_t    decode;
    } expected_decode_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       done;
    logic [5:0] operation_code;
    logic [5:0] first_operand;
    logic [5:0] second_operand;

    fetch_t           fetch_queue[$];
    expected_decode_t expected_decodes[$];
    int               mismatch_count;
    int               burst_left;
    int               gap_left;

    sm83_opcode_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .done           (done),
        .operation_code (operation_code),
        .first_operand  (first_operand),
        .second_operand (second_operand)
    );

    function automatic decode_t decoded(input logic [5:0] op, input logic [5:0] dst,
                                        input logic [5:0] src);
        decode_t d;
        d.op  = op;
        d.dst = dst;
        d.src = src;
        return d;
    endfunction

    // B, C, D, E, H, L, [HL], A in register-field order.
    function automatic logic [5:0] reg8_operand(input logic [2:0] sel);
        return OD_B + {3'b000, sel};
    endfunction

    function automatic logic [5:0] pair_sp_operand(input logic [1:0] sel);
        return (sel == 2'd3) ? OD_SP : OD_BC + {4'b0000, sel};
    endfunction

    function automatic logic [5:0] pair_af_operand(input logic [1:0] sel);
        return OD_BC + {4'b0000, sel};
    endfunction

    function automatic logic [5:0] cond_operand(input logic [1:0] sel);
        return OD_NZ + {4'b0000, sel};
    endfunction

    function automatic decode_t decode_instruction(input logic [7:0] fb, input logic [7:0] sb);
        logic [2:0] low;
        logic [2:0] mid;
        logic [1:0] pair;
        logic [1:0] sub;
        decode_t    d;
        d = decoded(OP_INVALID, OD_NONE, OD_NONE);
        if (fb == PREFIX_BYTE)
        begin
            low = sb[2:0];
            mid = sb[5:3];
            case (sb[7:6])
                2'b00: d = decoded(OP_RLC + {3'b000, mid}, reg8_operand(low), OD_NONE);
                2'b01: d = decoded(OP_BIT, OD_BIT0 + {3'b000, mid}, reg8_operand(low));
                2'b10: d = decoded(OP_RES, OD_BIT0 + {3'b000, mid}, reg8_operand(low));
                default: d = decoded(OP_SET, OD_BIT0 + {3'b000, mid}, reg8_operand(low));
            endcase
            return d;
        end
        low  = fb[2:0];
        mid  = fb[5:3];
        pair = fb[5:4];
        sub  = fb[4:3];
        case (fb[7:6])
            2'b00:
                case (low)
                    3'd0:
                        if (mid[2])
                            d = decoded(OP_JR, cond_operand(sub), OD_SIMM8);
                        else
                            case (sub)
                                2'd0: d = decoded(OP_NOP, OD_NONE, OD_NONE);
                                2'd1: d = decoded(OP_LD16, OD_MIMM16, OD_SP);
                                2'd2: d = decoded(OP_STOP, OD_IMM8, OD_NONE);
                                default: d = decoded(OP_JR, OD_SIMM8, OD_NONE);
                            endcase
                    3'd1:
                        if (fb[3])
                            d = decoded(OP_ADD16, OD_HL, pair_sp_operand(pair));
                        else
                            d = decoded(OP_LD16, pair_sp_operand(pair), OD_IMM16);
                    3'd2:
                        if (fb[3])
                            d = decoded(OP_LD8, OD_A, OD_MBC + {4'b0000, pair});
                        else
                            d = decoded(OP_LD8, OD_MBC + {4'b0000, pair}, OD_A);
                    3'd3:
                        d = decoded(fb[3] ? OP_DEC16 : OP_INC16, pair_sp_operand(pair), OD_NONE);
                    3'd4: d = decoded(OP_INC8, reg8_operand(mid), OD_NONE);
                    3'd5: d = decoded(OP_DEC8, reg8_operand(mid), OD_NONE);
                    3'd6: d = decoded(OP_LD8, reg8_operand(mid), OD_IMM8);
                    default: d = decoded(OP_RLCA + {3'b000, mid}, OD_NONE, OD_NONE);
                endcase
            2'b01:
                if (fb == HALT_BYTE)
                    d = decoded(OP_HALT, OD_NONE, OD_NONE);
                else
                    d = decoded(OP_LD8, reg8_operand(mid), reg8_operand(low));
            2'b10:
                d = decoded(OP_ADD8 + {3'b000, mid}, OD_A, reg8_operand(low));
            default:
                case (low)
                    3'd0:
                        if (!fb[5])
                            d = decoded(OP_RET, cond_operand(sub), OD_NONE);
                        else
                            case (sub)
                                2'd0: d = decoded(OP_LD8, OD_MHIGH8, OD_A);
                                2'd1: d = decoded(OP_ADD16, OD_SP, OD_SIMM8);
                                2'd2: d = decoded(OP_LD8, OD_A, OD_MHIGH8);
                                default: d = decoded(OP_LD16, OD_HL, OD_SPREL);
                            endcase
                    3'd1:
                        if (!fb[3])
                            d = decoded(OP_POP, pair_af_operand(pair), OD_NONE);
                        else
                            case (pair)
                                2'd0: d = decoded(OP_RET, OD_NONE, OD_NONE);
                                2'd1: d = decoded(OP_RETI, OD_NONE, OD_NONE);
                                2'd2: d = decoded(OP_JP, OD_HL, OD_NONE);
                                default: d = decoded(OP_LD16, OD_SP, OD_HL);
                            endcase
                    3'd2:
                        if (!fb[5])
                            d = decoded(OP_JP, cond_operand(sub), OD_IMM16);
                        else
                            case (sub)
                                2'd0: d = decoded(OP_LD8, OD_MHIGHC, OD_A);
                                2'd1: d = decoded(OP_LD8, OD_MIMM16, OD_A);
                                2'd2: d = decoded(OP_LD8, OD_A, OD_MHIGHC);
                                default: d = decoded(OP_LD8, OD_A, OD_MIMM16);
                            endcase
                    3'd3:
                        if (fb == JP_IMM_BYTE)
                            d = decoded(OP_JP, OD_IMM16, OD_NONE);
                        else if (fb == DI_BYTE)
                            d = decoded(OP_DI, OD_NONE, OD_NONE);
                        else if (fb == EI_BYTE)
                            d = decoded(OP_EI, OD_NONE, OD_NONE);
                    3'd4:
                        if (!fb[5])
                            d = decoded(OP_CALL, cond_operand(sub), OD_IMM16);
                    3'd5:
                        if (!fb[3])
                            d = decoded(OP_PUSH, pair_af_operand(pair), OD_NONE);
                        else if (fb == CALL_IMM_BYTE)
                            d = decoded(OP_CALL, OD_IMM16, OD_NONE);
                    3'd6: d = decoded(OP_ADD8 + {3'b000, mid}, OD_A, OD_IMM8);
                    default: d = decoded(OP_RST, OD_RST0 + {3'b000, mid}, OD_NONE);
                endcase
        endcase
        return d;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [7:0] fb, input logic [7:0] sb);
        fetch_t f;
        f.drain  = 1'b0;
        f.first  = fb;
        f.second = sb;
        fetch_queue.push_back(f);
    endtask

    // A drain entry holds the sender off until every outstanding request has its result.
    task automatic queue_drain();
        fetch_t f;
        f = '0;
        f.drain = 1'b1;
        fetch_queue.push_back(f);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Sender: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin
        fetch_t           f;
        expected_decode_t e;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                e.first  = first_byte;
                e.second = second_byte;
                e.decode = decode_instruction(first_byte, second_byte);
                expected_decodes.push_back(e);
            end
            if (start && busy)
            begin
                // The request has not been taken yet, so it stays on the inputs.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start       <= 1'b0;
                first_byte  <= 8'($urandom);
                second_byte <= 8'($urandom);
            end
            else if (fetch_queue.size() != 0 && fetch_queue[0].drain)
            begin
                start <= 1'b0;
                if (expected_decodes.size() == 0)
                    f = fetch_queue.pop_front();
            end
            else if (fetch_queue.size() != 0)
            begin
                f = fetch_queue.pop_front();
                first_byte  <= f.first;
                second_byte <= f.second;
                start       <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    gap_left   = $urandom_range(8, 1);
                    burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40)
                                                              : $urandom_range(12, 1);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Receiver: every result must match the oldest outstanding request.
    always @(posedge clk)
    begin
        expected_decode_t e;
        if (rst_n && done)
        begin
            if (expected_decodes.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d/%0d/%0d with no request outstanding",
                                        operation_code, first_operand, second_operand));
            end
            else
            begin
                e = expected_decodes.pop_front();
                if (operation_code !== e.decode.op)
                    flag_mismatch($sformatf("bytes %02h %02h: operation_code %0d, want %0d",
                                            e.first, e.second, operation_code, e.decode.op));
                if (first_operand !== e.decode.dst)
                    flag_mismatch($sformatf("bytes %02h %02h: first_operand %0d, want %0d",
                                            e.first, e.second, first_operand, e.decode.dst));
                if (second_operand !== e.decode.src)
                    flag_mismatch($sformatf("bytes %02h %02h: second_operand %0d, want %0d",
                                            e.first, e.second, second_operand, e.decode.src));
            end
        end
    end

    initial
    begin
        int         i;
        int         j;
        logic [7:0] order [0:255];
        logic [7:0] swap;
        rst_n          = 1'b0;
        start          = 1'b0;
        first_byte     = 8'h00;
        second_byte    = 8'h00;
        mismatch_count = 0;
        gap_left       = 0;
        burst_left     = $urandom_range(12, 1);

        // Field extremes, the special single bytes, every unused opcode, and the prefix.
        queue_request(8'h00, 8'h00);
        queue_request(8'hFF, 8'hFF);
        queue_request(8'h40, 8'hFF);
        queue_request(HALT_BYTE, 8'h00);
        queue_request(JP_IMM_BYTE, 8'hFF);
        queue_request(DI_BYTE, 8'h00);
        queue_request(EI_BYTE, 8'hFF);
        queue_request(CALL_IMM_BYTE, 8'h00);
        queue_request(8'h10, 8'hFF);
        queue_request(8'hD3, 8'h00);
        queue_request(8'hDB, 8'hFF);
        queue_request(8'hDD, 8'h00);
        queue_request(8'hE3, 8'hFF);
        queue_request(8'hE4, 8'h00);
        queue_request(8'hEB, 8'hFF);
        queue_request(8'hEC, 8'h00);
        queue_request(8'hED, 8'hFF);
        queue_request(8'hF4, 8'h00);
        queue_request(8'hFC, 8'hFF);
        queue_request(8'hFD, 8'h00);
        queue_request(PREFIX_BYTE, 8'h00);
        queue_request(PREFIX_BYTE, 8'h3F);
        queue_request(PREFIX_BYTE, 8'h40);
        queue_request(PREFIX_BYTE, 8'hFF);
        queue_drain();

        // Every first byte once in shuffled order, then every prefixed byte likewise.
        for (i = 0; i < 256; i++)
            order[i] = i[7:0];
        for (i = 255; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < 256; i++)
            queue_request(order[i], 8'($urandom));
        queue_drain();
        for (i = 255; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < 256; i++)
            queue_request(PREFIX_BYTE, order[i]);

        for (i = 0; i < 820; i++)
        begin
            if ($urandom_range(9, 0) < 4)
                queue_request(PREFIX_BYTE, 8'($urandom));
            else
                queue_request(8'($urandom), 8'($urandom));
            if (i % 200 == 199)
                queue_drain();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (fetch_queue.size() != 0 || start || expected_decodes.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sm83d_pkg.sv
hdl/sm83d_classify.sv
hdl/sm83d_decode.sv
hdl/sm83d_emit.sv
hdl/sm83_opcode_decoder_top.sv
tb/testbench.sv
